// ===== design/chm_pkg.sv =====
package chm_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_BUCKETS = 512;

  localparam int PTR_W  = $clog2(MAX_ENTRIES) + 1;
  localparam int EIDX_W = $clog2(MAX_ENTRIES);
  localparam int BIDX_W = $clog2(MAX_BUCKETS);
  localparam int BCNT_W = $clog2(MAX_BUCKETS) + 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES) + 1;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int LIM_W  = 9;
  localparam int CFG_W  = 10;
  localparam int PROD_W = CNT_W + BCNT_W;

  localparam logic [PTR_W-1:0]  NIL          = PTR_W'(MAX_ENTRIES);
  localparam logic [BCNT_W-1:0] INIT_BKT_RST = BCNT_W'(5);
  localparam logic [LIM_W-1:0]  LIMIT_RST    = LIM_W'(70);
  localparam logic [PROD_W-1:0] PERCENT      = PROD_W'(100);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_INIT  = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_ASSIGN = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [KEY_W-1:0]         key;
    logic signed [VAL_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic signed [VAL_W-1:0]  found_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic [BCNT_W-1:0]        bucket_total;
    logic                     rehashed;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_HSEL,
    OP_HLAT,
    OP_WREAD,
    OP_WCMP,
    OP_FIND,
    OP_MISS,
    OP_ER1,
    OP_ER2,
    OP_UPD,
    OP_FULL,
    OP_ADD0,
    OP_ADD1,
    OP_RH_START,
    OP_RH_COPY,
    OP_RH_BRD,
    OP_RH_BQ,
    OP_RH_NEXTB,
    OP_RH_ERD,
    OP_RH_EQ,
    OP_RH_HSEL,
    OP_RH_LINK,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic  clr_req;
    logic  clr_last;
    logic  mod_busy;
    logic  e_nil;
    logic  hit;
    logic  found;
    mode_t mode;
    logic  free_nil;
    logic  over;
    logic  bcnt_big;
    logic  copy_last;
    logic  b_end;
    logic  out_free;
  } stat_t;

endpackage

// ===== design/chained_hash_map_engine.sv =====
// chained hash map: one operation per input transfer (insert, find, erase,
// assign), one result transfer per operation. the key mod bucket count is
// computed bit-serially and the chain walk is single-port. an insert
// that pushes the load past the limit doubles the bucket count and rehashes
// every entry held, or reports full if over half the maximum buckets are in
// use. after reset and after each write of initial_buckets a clearing pass
// runs with in_stall high. a finished result sits in the output register
// while the next item is taken.
module chained_hash_map_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  // input item channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  chm_pkg::in_t              in_data,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output chm_pkg::out_t             out_data,
  // configuration writes: index 0 initial_buckets, index 1 load_limit_percent
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [chm_pkg::CFG_W-1:0] cfg_data
);
  import chm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: clearing pass, lookup walk, edits, rehash, result transfer
  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, free list, modulo unit and output register
  chm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/chm_mod.sv =====
module chm_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [chm_pkg::KEY_W-1:0]  dividend,
  input  logic [chm_pkg::BCNT_W-1:0] divisor,
  output logic                       busy,
  output logic [chm_pkg::BCNT_W-1:0] rem
);
  import chm_pkg::*;

  localparam int STEP_W = $clog2(KEY_W);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [BCNT_W-1:0] rem_r;
  logic [KEY_W-1:0]  dvd_r;
  logic [BCNT_W-1:0] dvs_r;
  logic [BCNT_W:0]   trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_r, dvd_r[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(KEY_W - 1);
      rem_r  <= '0;
      dvd_r  <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) rem_r <= BCNT_W'(trial - {1'b0, dvs_r});
      else rem_r <= trial[BCNT_W-1:0];
      dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
      if (step_r == '0) busy_r <= 1'b0;
      else step_r <= step_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== design/chm_datapath.sv =====
module chm_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  chm_pkg::in_t              in_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [chm_pkg::CFG_W-1:0] cfg_data,
  input  chm_pkg::cmd_t             cmd,
  output chm_pkg::stat_t            stat,
  output logic                      out_valid,
  input  logic                      out_stall,
  output chm_pkg::out_t             out_data
);
  import chm_pkg::*;

  logic [LIM_W-1:0]  limit_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PTR_W-1:0]  free_r;
  logic [BCNT_W-1:0] idx_r;
  mode_t             mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [PTR_W-1:0]  e_r;
  logic [PTR_W-1:0]  prev_r;
  logic [PTR_W-1:0]  nx_r;
  logic [PTR_W-1:0]  head_r;
  logic [BIDX_W-1:0] h_r;
  logic              found_r;
  logic [VAL_W-1:0]  fval_r;
  logic [1:0]        status_r;
  logic              dbl_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [PTR_W-1:0]  heads_mem [MAX_BUCKETS];
  logic [PTR_W-1:0]  old_mem   [MAX_BUCKETS];
  logic [KEY_W-1:0]  keys_mem  [MAX_ENTRIES];
  logic [VAL_W-1:0]  vals_mem  [MAX_ENTRIES];
  logic [PTR_W-1:0]  links_mem [MAX_ENTRIES];

  logic [PTR_W-1:0]  heads_q, old_q, links_q;
  logic [KEY_W-1:0]  keys_q;
  logic [VAL_W-1:0]  vals_q;

  logic              heads_we, old_we, keys_we, vals_we, links_we;
  logic [BIDX_W-1:0] heads_wa, heads_ra;
  logic [PTR_W-1:0]  heads_wd;
  logic [EIDX_W-1:0] links_wa, links_ra;
  logic [PTR_W-1:0]  links_wd;

  logic              mod_start, mod_busy;
  logic [KEY_W-1:0]  mod_dvd;
  logic [BCNT_W-1:0] mod_rem;
  logic              init_wr;

  function automatic logic [BCNT_W-1:0] clamp_bkt(input logic [CFG_W-1:0] v);
    logic [BCNT_W-1:0] r;
    r = BCNT_W'(v);
    if (v == '0) r = BCNT_W'(1);
    else if (v > CFG_W'(MAX_BUCKETS)) r = BCNT_W'(MAX_BUCKETS);
    return r;
  endfunction

  assign init_wr   = cfg_we && (cfg_index == CFG_INIT);
  assign mod_start = (cmd.op == OP_LOAD) || (cmd.op == OP_RH_EQ);
  assign mod_dvd   = (cmd.op == OP_LOAD) ? in_data.key : keys_q;

  chm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (bcnt_r),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // memory ports
  always_comb begin
    heads_we = 1'b0;
    heads_wa = h_r;
    heads_wd = e_r;
    heads_ra = h_r;
    links_we = 1'b0;
    links_wa = e_r[EIDX_W-1:0];
    links_wd = e_r;
    links_ra = e_r[EIDX_W-1:0];
    unique case (cmd.op)
      OP_CLR: begin
        heads_we = 1'b1;
        heads_wa = idx_r[BIDX_W-1:0];
        heads_wd = NIL;
        links_we = (idx_r < BCNT_W'(MAX_ENTRIES));
        links_wa = idx_r[EIDX_W-1:0];
        links_wd = PTR_W'(idx_r + 1'b1);
      end
      OP_HSEL, OP_RH_HSEL: heads_ra = mod_rem[BIDX_W-1:0];
      OP_RH_COPY: begin
        heads_ra = idx_r[BIDX_W-1:0];
        heads_we = (idx_r < bcnt_r);
        heads_wa = idx_r[BIDX_W-1:0];
        heads_wd = NIL;
      end
      OP_ER1: begin
        heads_we = (prev_r == NIL);
        heads_wd = links_q;
        links_we = (prev_r != NIL);
        links_wa = prev_r[EIDX_W-1:0];
        links_wd = links_q;
      end
      OP_ER2: begin
        links_we = 1'b1;
        links_wd = free_r;
      end
      OP_ADD0: links_ra = free_r[EIDX_W-1:0];
      OP_ADD1: begin
        heads_we = 1'b1;
        links_we = 1'b1;
        links_wd = head_r;
      end
      OP_RH_LINK: begin
        heads_we = 1'b1;
        links_we = 1'b1;
        links_wd = heads_q;
      end
      default: ;
    endcase
  end

  assign old_we  = (cmd.op == OP_RH_COPY) && (idx_r != '0);
  assign keys_we = (cmd.op == OP_ADD1);
  assign vals_we = (cmd.op == OP_ADD1) || (cmd.op == OP_UPD);

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[heads_wa] <= heads_wd;
    heads_q <= heads_mem[heads_ra];
  end

  always_ff @(posedge clk) begin
    if (old_we) old_mem[BIDX_W'(idx_r - 1'b1)] <= heads_q;
    old_q <= old_mem[idx_r[BIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (keys_we) keys_mem[e_r[EIDX_W-1:0]] <= key_r;
    keys_q <= keys_mem[e_r[EIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vals_we) vals_mem[e_r[EIDX_W-1:0]] <= val_r;
    vals_q <= vals_mem[e_r[EIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (links_we) links_mem[links_wa] <= links_wd;
    links_q <= links_mem[links_ra];
  end

  // table control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      bcnt_r  <= INIT_BKT_RST;
      cnt_r   <= '0;
      free_r  <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_LIMIT)) limit_r <= cfg_data[LIM_W-1:0];
      if (init_wr) begin
        bcnt_r <= clamp_bkt(cfg_data);
        cnt_r  <= '0;
        free_r <= '0;
        idx_r  <= '0;
      end else begin
        unique case (cmd.op)
          OP_CLR:      idx_r <= idx_r + 1'b1;
          OP_ER2: begin
            free_r <= e_r;
            cnt_r  <= cnt_r - 1'b1;
          end
          OP_ADD1: begin
            free_r <= links_q;
            cnt_r  <= cnt_r + 1'b1;
          end
          OP_RH_START: begin
            bcnt_r <= {bcnt_r[BCNT_W-2:0], 1'b0};
            idx_r  <= '0;
          end
          OP_RH_COPY:  idx_r <= stat.copy_last ? '0 : idx_r + 1'b1;
          OP_RH_NEXTB: idx_r <= idx_r + 1'b1;
          default: ;
        endcase
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mode_r   <= in_data.mode;
        key_r    <= in_data.key;
        val_r    <= in_data.value;
        found_r  <= 1'b0;
        fval_r   <= '0;
        status_r <= ST_OK;
        dbl_r    <= 1'b0;
      end
      OP_HSEL, OP_RH_HSEL: h_r <= mod_rem[BIDX_W-1:0];
      OP_HLAT: begin
        e_r    <= heads_q;
        head_r <= heads_q;
        prev_r <= NIL;
      end
      OP_WCMP: begin
        if (keys_q == key_r) found_r <= 1'b1;
        else begin
          prev_r <= e_r;
          e_r    <= links_q;
        end
      end
      OP_FIND:     fval_r <= vals_q;
      OP_MISS:     status_r <= ST_MISS;
      OP_FULL:     status_r <= ST_FULL;
      OP_ADD0:     e_r <= free_r;
      OP_RH_START: dbl_r <= 1'b1;
      OP_RH_BQ:    e_r <= old_q;
      OP_RH_EQ:    nx_r <= links_q;
      OP_RH_LINK:  e_r <= nx_r;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_r.found        <= found_r;
      out_r.found_value  <= fval_r;
      out_r.status       <= status_r;
      out_r.entry_count  <= cnt_r;
      out_r.bucket_total <= bcnt_r;
      out_r.rehashed     <= dbl_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.clr_req   = init_wr;
    stat.clr_last  = (idx_r == BCNT_W'(MAX_BUCKETS - 1));
    stat.mod_busy  = mod_busy;
    stat.e_nil     = (e_r == NIL);
    stat.hit       = (keys_q == key_r);
    stat.found     = found_r;
    stat.mode      = mode_r;
    stat.free_nil  = (free_r == NIL);
    stat.over      = ({{BCNT_W{1'b0}}, cnt_r} * PERCENT) >
                     ({{BCNT_W{1'b0}}, limit_r} * {{CNT_W{1'b0}}, bcnt_r});
    stat.bcnt_big  = (bcnt_r > BCNT_W'(MAX_BUCKETS / 2));
    stat.copy_last = (idx_r == bcnt_r);
    stat.b_end     = (idx_r == {1'b0, bcnt_r[BCNT_W-1:1]});
    stat.out_free  = !out_valid_r || !out_stall;
  end

endmodule

// ===== design/chm_ctrl.sv =====
module chm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  chm_pkg::stat_t stat,
  output chm_pkg::cmd_t  cmd
);
  import chm_pkg::*;

  typedef enum logic [17:0] {
    S_CLEAR = 18'h00001,
    S_IDLE  = 18'h00002,
    S_HMOD  = 18'h00004,
    S_HRD   = 18'h00008,
    S_WALK  = 18'h00010,
    S_WCMP  = 18'h00020,
    S_DISP  = 18'h00040,
    S_ER2   = 18'h00080,
    S_ADD1  = 18'h00100,
    S_CHK   = 18'h00200,
    S_COPY  = 18'h00400,
    S_BRD   = 18'h00800,
    S_BQ    = 18'h01000,
    S_RE    = 18'h02000,
    S_REQ   = 18'h04000,
    S_RMOD  = 18'h08000,
    S_RLINK = 18'h10000,
    S_FIN   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_HMOD;
        end
      end
      S_HMOD: begin
        if (!stat.mod_busy) begin
          cmd.op    = OP_HSEL;
          state_nxt = S_HRD;
        end
      end
      S_HRD: begin
        cmd.op    = OP_HLAT;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (stat.e_nil) state_nxt = S_DISP;
        else begin
          cmd.op    = OP_WREAD;
          state_nxt = S_WCMP;
        end
      end
      S_WCMP: begin
        cmd.op    = OP_WCMP;
        state_nxt = stat.hit ? S_DISP : S_WALK;
      end
      S_DISP: begin
        priority if (stat.mode == MODE_FIND) begin
          cmd.op    = stat.found ? OP_FIND : OP_MISS;
          state_nxt = S_FIN;
        end else if (stat.mode == MODE_ERASE) begin
          cmd.op    = stat.found ? OP_ER1 : OP_MISS;
          state_nxt = stat.found ? S_ER2 : S_FIN;
        end else if (stat.mode == MODE_ASSIGN && stat.found) begin
          cmd.op    = OP_UPD;
          state_nxt = S_FIN;
        end else if (stat.free_nil) begin
          cmd.op    = OP_FULL;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_ADD0;
          state_nxt = S_ADD1;
        end
      end
      S_ER2: begin
        cmd.op    = OP_ER2;
        state_nxt = S_FIN;
      end
      S_ADD1: begin
        cmd.op    = OP_ADD1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        priority if (!stat.over) state_nxt = S_FIN;
        else if (stat.bcnt_big) begin
          cmd.op    = OP_FULL;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_RH_START;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.op = OP_RH_COPY;
        if (stat.copy_last) state_nxt = S_BRD;
      end
      S_BRD: begin
        if (stat.b_end) state_nxt = S_CHK;
        else begin
          cmd.op    = OP_RH_BRD;
          state_nxt = S_BQ;
        end
      end
      S_BQ: begin
        cmd.op    = OP_RH_BQ;
        state_nxt = S_RE;
      end
      S_RE: begin
        if (stat.e_nil) begin
          cmd.op    = OP_RH_NEXTB;
          state_nxt = S_BRD;
        end else begin
          cmd.op    = OP_RH_ERD;
          state_nxt = S_REQ;
        end
      end
      S_REQ: begin
        cmd.op    = OP_RH_EQ;
        state_nxt = S_RMOD;
      end
      S_RMOD: begin
        if (!stat.mod_busy) begin
          cmd.op    = OP_RH_HSEL;
          state_nxt = S_RLINK;
        end
      end
      S_RLINK: begin
        cmd.op    = OP_RH_LINK;
        state_nxt = S_RE;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (stat.clr_req) begin
      cmd.op    = OP_NONE;
      state_nxt = S_CLEAR;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== design/chm_checker.sv =====
module chm_props (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input chm_pkg::out_t out_data
);
  import chm_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a miss never reports a match
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_MISS) |-> !out_data.found)
    else $error("miss with found set");

  // doubling leaves at least two buckets and a stored entry
  a_dbl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rehashed |->
      (out_data.bucket_total >= 2) && (out_data.entry_count != 0))
    else $error("rehash flag inconsistent");

  // counts stay in range
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= MAX_ENTRIES) &&
      (out_data.bucket_total != 0) && (out_data.bucket_total <= MAX_BUCKETS) &&
      (out_data.status != 2'd3))
    else $error("result field out of range");

endmodule

bind chained_hash_map_engine chm_props u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
